// ===== sv/spq_pkg.sv =====
// Shared types, codes and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default number of entries the queue can hold.
    localparam int DEPTH_DEF = 64;

    // Field widths of the item and result.
    localparam int PRI_W   = 32;
    localparam int ID_W    = 32;
    localparam int KEY_W   = PRI_W + ID_W;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Action codes of an input item.
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // One input item.
    typedef struct packed {
        logic             action;
        logic [PRI_W-1:0] new_priority;
        logic [ID_W-1:0]  new_id;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PRI_W-1:0]   out_priority;
        logic [ID_W-1:0]    out_id;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_item;
        logic              idx_dec;
        logic              idx_inc;
        logic              idx_clear;
        logic              rd_below;
        logic              rd_above;
        logic              rd_first;
        logic              wr_new;
        logic              wr_shift;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              capture_out;
        logic              load_result;
        logic [STAT_W-1:0] res_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic action;
        logic full;
        logic empty;
        logic idx_zero;
        logic new_less;
        logic shift_done;
    } sts_t;

endpackage : spq_pkg

`default_nettype wire

// ===== sv/spq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : spq_ram

`default_nettype wire

// ===== sv/spq_datapath.sv =====
// Datapath of the queue: entry memory, insert position index, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire item_t   s_item,
    input  wire cmd_t    cmd,
    output sts_t         sts,
    output result_t      m_item
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            item_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PRI_W-1:0] deq_pri_reg;
    logic [ID_W-1:0]  deq_id_reg;
    result_t          m_item_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] new_key;
    logic [CNT_W:0]   idx_plus;

    assign new_key  = {item_reg.new_priority, item_reg.new_id};
    assign idx_plus = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};

    // Entry memory: one key per slot, priority in the upper half.
    spq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Memory address and data selection.
    always_comb begin
        ram_re    = cmd.rd_below | cmd.rd_above | cmd.rd_first;
        ram_raddr = '0;
        if (cmd.rd_below) begin
            ram_raddr = AW'(idx_reg - {{(CNT_W-1){1'b0}}, 1'b1});
        end else if (cmd.rd_above) begin
            ram_raddr = AW'(idx_plus);
        end
        ram_we    = cmd.wr_new | cmd.wr_shift;
        ram_waddr = AW'(idx_reg);
        ram_wdata = cmd.wr_new ? new_key : ram_rdata;
    end

    // Status toward the controller.
    always_comb begin
        sts.action     = item_reg.action;
        sts.full       = (cnt_reg >= CNT_W'(DEPTH));
        sts.empty      = (cnt_reg == '0);
        sts.idx_zero   = (idx_reg == '0);
        sts.new_less   = (new_key < ram_rdata);
        sts.shift_done = (idx_plus >= {1'b0, cnt_reg});
    end

    // Index and count updates.
    always_comb begin
        idx_next = idx_reg;
        if (cmd.load_item) begin
            idx_next = cnt_reg;
        end else if (cmd.idx_clear) begin
            idx_next = '0;
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (cmd.idx_inc) begin
            idx_next = CNT_W'(idx_plus);
        end
        cnt_next = cnt_reg;
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    // Stored entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_item) begin
            item_reg    <= s_item;
            deq_pri_reg <= '0;
            deq_id_reg  <= '0;
        end else if (cmd.capture_out) begin
            deq_pri_reg <= ram_rdata[KEY_W-1:ID_W];
            deq_id_reg  <= ram_rdata[ID_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_item_reg.status       <= cmd.res_status;
            m_item_reg.out_priority <= deq_pri_reg;
            m_item_reg.out_id       <= deq_id_reg;
            m_item_reg.entry_count  <= COUNT_W'(cnt_reg);
            m_item_reg.is_empty     <= (cnt_reg == '0);
        end
    end

    assign m_item = m_item_reg;

`ifndef SYNTHESIS
    // The count never goes past the capacity.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // Every memory write lands inside the array.
    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (idx_reg < CNT_W'(DEPTH)))
        else $error("memory write out of range");

    // An insert moves entries only while the queue has room.
    a_shift_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (cnt_reg < CNT_W'(DEPTH) || cmd.wr_shift && item_reg.action == ACT_DEQUEUE))
        else $error("memory write while queue full");

    // Count changes by at most one entry per item completion step.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("count incremented and decremented together");
`endif

endmodule : spq_datapath

`default_nettype wire

// ===== sv/spq_ctrl.sv =====
// Controller state machine that sequences inserts and dequeues over the entry memory.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_DEQ_CAP  = 3'd3;
    localparam logic [2:0] S_DEQ_STEP = 3'd4;
    localparam logic [2:0] S_DEQ_MOVE = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && aresetn;
    assign m_valid = m_valid_reg;

    // Next state and command decode.
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        cmd            = '0;
        cmd.res_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_item = 1'b1;
                    status_next   = ST_DONE;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.action == ACT_INSERT) begin
                    if (sts.full) begin
                        status_next = ST_FULL;
                        state_next  = S_FINISH;
                    end else if (sts.idx_zero) begin
                        cmd.wr_new  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_FINISH;
                    end else begin
                        cmd.rd_below = 1'b1;
                        state_next   = S_INS_CMP;
                    end
                end else begin
                    if (sts.empty) begin
                        status_next = ST_EMPTY;
                        state_next  = S_FINISH;
                    end else begin
                        cmd.rd_first = 1'b1;
                        state_next   = S_DEQ_CAP;
                    end
                end
            end
            S_INS_CMP: begin
                // Move a larger entry up one slot, or drop the new entry in.
                if (sts.new_less) begin
                    cmd.wr_shift = 1'b1;
                    cmd.idx_dec  = 1'b1;
                    state_next   = S_DECIDE;
                end else begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DEQ_CAP: begin
                cmd.capture_out = 1'b1;
                cmd.idx_clear   = 1'b1;
                state_next      = S_DEQ_STEP;
            end
            S_DEQ_STEP: begin
                if (sts.shift_done) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.rd_above = 1'b1;
                    state_next   = S_DEQ_MOVE;
                end
            end
            S_DEQ_MOVE: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_DEQ_STEP;
            end
            S_FINISH: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // Loading a result always returns the controller to idle.
    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> (state_reg == S_IDLE && m_valid_reg))
        else $error("result load did not end the item");

    // A new item is taken only when idle.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |-> (state_reg == S_IDLE))
        else $error("item loaded while busy");
`endif

endmodule : spq_ctrl

`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller, datapath and result handshake.
//
// Usage: the input channel (s_valid, s_ready, s_item) takes one item, either an
// insert of a (priority, id) entry or a dequeue of the smallest entry. Entries
// are held in ascending order of priority, then id; equal keys keep arrival order.
// Each item gives exactly one result on the output channel (m_valid, m_ready,
// m_item) with a status, the dequeued entry (zero otherwise), the count and an
// empty flag. A full queue refuses an insert, an empty one refuses a dequeue.
// Timing: items are worked one at a time on a memory with one read and one
// write port and a registered read. An insert walks down from the top entry,
// moving each entry greater than the new key up one slot, then writes the new
// key into the free slot; a dequeue reads the first slot, then moves each
// remaining entry down one slot. Refused items go straight to the result. The
// next item can be accepted in the cycle after the result is loaded; no item
// is taken while another is still being worked.
// Reset (aresetn low at a clock edge) empties the queue at once; no clearing
// pass is needed, and s_ready stays low while reset is held. The finished
// result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, the following item holds at its last step
// until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire item_t   s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_item
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Entry storage and result formation.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_item  (m_item)
    );

endmodule : sorted_priority_queue

`default_nettype wire

// ===== tb/sorted_priority_queue_test.sv =====
// Self-checking testbench of the sorted priority queue, with a driver, a monitor and a predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 600;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 24;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

    // One item waiting in the driver, with the idle cycles to insert before it.
    typedef struct {
        item_t       item;
        int unsigned gap;
    } pending_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    item_t   s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_item;

    pending_t    pending[$];
    pending_t    next_up;
    int unsigned total_items;
    int unsigned in_sent     = 0;
    int unsigned in_taken    = 0;
    int unsigned gap_done    = 0;
    int unsigned rx_stall    = 0;
    int unsigned rx_cycle    = 0;
    bit          rx_hold     = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;

    // Entries of the predicted queue, kept as {priority, id} keys in ascending order.
    logic [KEY_W-1:0] sorted_keys[$];
    result_t          expected_results[$];
    result_t          want;

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    // Free-running clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Applies one item to the predicted queue and returns the result it should give.
    function automatic result_t predict_queue_op(item_t it);
        result_t          res;
        logic [KEY_W-1:0] key;
        int               pos;
        res = '0;
        res.status = ST_DONE;
        key = {it.new_priority, it.new_id};
        if (it.action == ACT_INSERT) begin
            if (sorted_keys.size() >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // The new entry goes ahead of the first strictly greater key.
                pos = 0;
                while (pos < sorted_keys.size() && sorted_keys[pos] <= key) begin
                    pos++;
                end
                sorted_keys.insert(pos, key);
            end
        end else begin
            if (sorted_keys.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                key = sorted_keys.pop_front();
                res.out_priority = key[KEY_W-1:ID_W];
                res.out_id       = key[ID_W-1:0];
            end
        end
        res.entry_count = COUNT_W'(sorted_keys.size());
        res.is_empty    = (sorted_keys.size() == 0);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // Key field value: small values make ties common, extremes show up regularly.
    function automatic logic [31:0] pick_field();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return $urandom_range(0, 7);
        end else if (r == 4) begin
            return 32'h0000_0000;
        end else if (r == 5) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    task automatic push_item(logic act, logic [PRI_W-1:0] pri, logic [ID_W-1:0] id,
                             int unsigned gap);
        pending_t p;
        p.item.action       = act;
        p.item.new_priority = pri;
        p.item.new_id       = id;
        p.gap               = gap;
        pending.push_back(p);
    endtask

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            end
        end
    endtask

    // Driver: presents pending items, holding each one until it is accepted.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && in_sent != in_taken) begin
            // The current item has not been taken yet, so it stays on the bus.
        end else if (pending.size() == 0) begin
            s_valid <= 1'b0;
        end else if (gap_done < pending[0].gap) begin
            gap_done++;
            s_valid <= 1'b0;
        end else begin
            next_up = pending.pop_front();
            s_item  <= next_up.item;
            s_valid <= 1'b1;
            in_sent++;
            gap_done = 0;
        end
    end

    // Receiver: random stalls, with calm windows and the long hold-off.
    always @(negedge aclk) begin
        rx_cycle++;
        if (!aresetn || rx_hold) begin
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ((rx_cycle / 300) % 3 != 0 && $urandom_range(0, 3) == 0) begin
                rx_stall = pick_gap();
            end
        end
    end

    // Long hold-off of the receiver so that the block backs up and stalls its input.
    initial begin
        wait (in_taken >= HOLD_AFTER);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // Monitor: predicts accepted items, checks results and watches for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_queue_op(s_item));
                in_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: result with no item outstanding, status %0d",
                                 $time, m_item.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_item.status));
                    check_field("out_priority", want.out_priority, m_item.out_priority);
                    check_field("out_id", want.out_id, m_item.out_id);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(m_item.entry_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(m_item.is_empty));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                    $display("sorted_priority_queue_test: errors");
                    $finish;
                end
            end
        end
    end

    // Stimulus, reset and end of the run.
    initial begin : stimulus
        phase_t      kind;
        int unsigned len;
        int unsigned ins_pct;
        bit          calm;
        int unsigned phase_idx;

        // Directed part: empty dequeue, extremes, ties and arrival order, then drain.
        push_item(ACT_DEQUEUE, 32'h0, 32'h0, 0);
        push_item(ACT_INSERT, 32'd5, 32'd100, 0);
        push_item(ACT_INSERT, 32'd5, 32'd50, 0);
        push_item(ACT_INSERT, 32'd5, 32'd100, 2);
        push_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 0);
        push_item(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1);
        push_item(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 0);
        push_item(ACT_INSERT, 32'd5, 32'd75, 0);
        push_item(ACT_INSERT, 32'd4, 32'hFFFF_FFFF, 0);
        push_item(ACT_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        repeat (9) push_item(ACT_DEQUEUE, 32'h0, 32'h0, 0);

        // Random part: fill, drain and mixed phases; the first one fills past full.
        phase_idx = 0;
        while (pending.size() < 20 + RANDOM_ITEMS) begin
            kind = phase_t'($urandom_range(0, 2));
            calm = ($urandom_range(0, 2) == 0);
            if (phase_idx == 0) begin
                kind = PH_FILL;
            end
            case (kind)
                PH_FILL: begin
                    len     = $urandom_range(70, 90);
                    ins_pct = (phase_idx == 0) ? 100 : 90;
                end
                PH_DRAIN: begin
                    len     = $urandom_range(70, 90);
                    ins_pct = 10;
                end
                default: begin
                    len     = $urandom_range(30, 50);
                    ins_pct = 50;
                end
            endcase
            repeat (len) begin
                push_item(($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DEQUEUE,
                          pick_field(), pick_field(), calm ? 0 : pick_gap());
            end
            phase_idx++;
        end
        total_items = pending.size();

        // Hold reset, then release it at a falling edge.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (in_taken < total_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("sorted_priority_queue_test: clean");
        end else begin
            $display("sorted_priority_queue_test: errors");
        end
        $finish;
    end

endmodule
